// ===== rtl/weighted_lru_cache_macros.svh =====
// assertion macros used by the checker file
// needs clk and rst_n in the scope that uses them
`ifndef WEIGHTED_LRU_CACHE_MACROS_SVH
`define WEIGHTED_LRU_CACHE_MACROS_SVH

// same-cycle implication
`define WLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weighted_lru_cache assertion failed");

// next-cycle implication
`define WLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted_lru_cache assertion failed");

`endif

// ===== rtl/wlc_pkg.sv =====
// types, codes and helpers of the weighted lru cache
// no dependencies
package wlc_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned WGT_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;
  localparam logic [1:0] OP_CLR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NF    = 2'd1;
  localparam logic [1:0] ST_HEAVY = 2'd2;

  localparam logic KIND_FINAL  = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY   = 1'd1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [WGT_W-1:0] weight;
  } wlc_in_t;

  typedef struct packed {
    logic             kind;
    logic [1:0]       status;
    logic [KEY_W-1:0] key_out;
    logic [VAL_W-1:0] value_out;
    logic [WGT_W-1:0] weight_out;
    logic [WGT_W-1:0] used_weight;
    logic [4:0]       entry_count;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] eviction_count;
    logic             last;
  } wlc_out_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [WGT_W-1:0] weight;
  } wlc_entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD = 3'd0,
    CMD_PREV = 3'd1,
    CMD_NEXT = 3'd2,
    CMD_LOAD = 3'd3,
    CMD_KILL = 3'd4
  } wlc_cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

endpackage

// ===== rtl/weighted_lru_cache.sv =====
// weighted lru key-value store built as a row of recency cells, most recent at cell 0
// depends on wlc_pkg and wlc_cell
//
// input channel in_valid/in_stall/in_data carries one request (get, set, delete, clear).
// output channel out_valid/out_stall/out_data returns eviction notices (when enabled)
// followed by one final response with last set; every result shows the state after
// the whole request. cfg_we/cfg_idx/cfg_wdata write capacity and the notice enable.
// a request is taken only while the block is idle; in_stall is high from acceptance
// until the final response is transferred.
// steps: a key match over all cells (registered), then the request is applied; a set
// of a new key that finds every cell full first evicts the last cell, then applies.
// a stored set then evicts the last cell while used weight exceeds capacity; a get,
// delete, clear or heavy set skips that step. then the results are shown in order.
// the next request is taken the cycle after the final transfer.
// reset empties all cells, zeroes the counters and used weight and restores
// capacity 4096 with notices off. while out_stall is high the shown result holds.
module weighted_lru_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  wlc_pkg::wlc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output wlc_pkg::wlc_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [wlc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [wlc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import wlc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_APPLY = 5'b00100,
    S_EVICT = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  wlc_in_t           req_r;
  logic [WGT_W-1:0]  cap_r;
  logic              notify_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [WGT_W:0]    total_r, total_nxt;
  logic [CNT_W-1:0]  hits_r, hits_nxt;
  logic [CNT_W-1:0]  misses_r, misses_nxt;
  logic [CNT_W-1:0]  evicts_r, evicts_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [VAL_W-1:0]  fval_r, fval_nxt;
  logic [ENTRIES-1:0] hv_r;
  logic [CW-1:0]     nq_r, nq_nxt;
  logic [CW-1:0]     rd_r, rd_nxt;
  wlc_entry_t        q_mem [ENTRIES];

  wlc_cmd_t          cmd [ENTRIES];
  wlc_entry_t        ent [ENTRIES];
  logic [ENTRIES-1:0] match;
  wlc_entry_t        load_ent;
  wlc_entry_t        hit_ent;
  wlc_entry_t        last_ent;
  logic [IW-1:0]     last_idx;
  logic [ENTRIES-1:0] from_mask;
  logic [ENTRIES-1:0] upto_mask;
  logic              hit;
  logic              do_evict;
  logic              q_we;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      wlc_entry_t prev_e, next_e;
      if (g == 0) begin : g_head
        assign prev_e = '0;
      end else begin : g_mid
        assign prev_e = ent[g-1];
      end
      if (g == ENTRIES - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_body
        assign next_e = ent[g+1];
      end
      wlc_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd[g]),
        .prev_i  (prev_e),
        .next_i  (next_e),
        .load_i  (load_ent),
        .key_i   (req_r.key),
        .ent_o   (ent[g]),
        .match_o (match[g])
      );
    end
  endgenerate

  always_comb begin
    logic [ENTRIES-1:0] ones;
    ones    = '1;
    hit     = |hv_r;
    hit_ent = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      from_mask[i] = |(hv_r & (ones << i));
      upto_mask[i] = |(hv_r & ~(ones << (i + 1)));
      if (hv_r[i]) begin
        hit_ent = hit_ent | ent[i];
      end
    end
    last_idx = IW'(count_r - 1'b1);
    last_ent = ent[last_idx];
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    evicts_nxt = evicts_r;
    status_nxt = status_r;
    fval_nxt   = fval_r;
    nq_nxt     = nq_r;
    rd_nxt     = rd_r;
    load_ent   = '0;
    do_evict   = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      cmd[i] = CMD_HOLD;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_MATCH;
          status_nxt = ST_OK;
          fval_nxt   = '0;
          nq_nxt     = '0;
          rd_nxt     = '0;
        end
      end
      S_MATCH: state_nxt = S_APPLY;
      S_APPLY: begin
        case (req_r.opcode)
          OP_GET: begin
            state_nxt = S_EMIT;
            if (hit) begin
              load_ent = hit_ent;
              cmd[0]   = CMD_LOAD;
              for (int i = 1; i < ENTRIES; i++) begin
                if (from_mask[i]) cmd[i] = CMD_PREV;
              end
              fval_nxt = hit_ent.value;
              hits_nxt = sat_inc(hits_r);
            end else begin
              status_nxt = ST_NF;
              misses_nxt = sat_inc(misses_r);
            end
          end
          OP_SET: begin
            if (req_r.weight > cap_r) begin
              status_nxt = ST_HEAVY;
              state_nxt  = S_EMIT;
            end else if (hit) begin
              load_ent = {1'b1, req_r.key, req_r.value, req_r.weight};
              cmd[0]   = CMD_LOAD;
              for (int i = 1; i < ENTRIES; i++) begin
                if (from_mask[i]) cmd[i] = CMD_PREV;
              end
              total_nxt = total_r - {1'b0, hit_ent.weight} + {1'b0, req_r.weight};
              state_nxt = S_EVICT;
            end else if (count_r == FULL) begin
              do_evict = 1'b1;
            end else begin
              load_ent = {1'b1, req_r.key, req_r.value, req_r.weight};
              cmd[0]   = CMD_LOAD;
              for (int i = 1; i < ENTRIES; i++) begin
                cmd[i] = CMD_PREV;
              end
              count_nxt = count_r + 1'b1;
              total_nxt = total_r + {1'b0, req_r.weight};
              state_nxt = S_EVICT;
            end
          end
          OP_DEL: begin
            state_nxt = S_EMIT;
            if (hit) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (!upto_mask[i] || hv_r[i]) begin
                  cmd[i] = (from_mask[i] && !hv_r[i]) ? CMD_HOLD : CMD_NEXT;
                end
              end
              for (int i = 0; i < ENTRIES; i++) begin
                cmd[i] = upto_mask[i] ? CMD_NEXT : CMD_HOLD;
              end
              total_nxt = total_r - {1'b0, hit_ent.weight};
              count_nxt = count_r - 1'b1;
            end else begin
              status_nxt = ST_NF;
            end
          end
          OP_CLR: begin
            for (int i = 0; i < ENTRIES; i++) begin
              cmd[i] = CMD_KILL;
            end
            count_nxt  = '0;
            total_nxt  = '0;
            hits_nxt   = '0;
            misses_nxt = '0;
            state_nxt  = S_EMIT;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_EVICT: begin
        if ((total_r > {1'b0, cap_r}) && (count_r != '0)) begin
          do_evict = 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (rd_r != nq_r) begin
            rd_nxt = rd_r + 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (do_evict) begin
      cmd[last_idx] = CMD_KILL;
      total_nxt     = total_r - {1'b0, last_ent.weight};
      count_nxt     = count_r - 1'b1;
      evicts_nxt    = sat_inc(evicts_r);
      if (notify_r) begin
        nq_nxt = nq_r + 1'b1;
      end
    end
  end

  assign q_we = do_evict && notify_r;

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[nq_r[IW-1:0]] <= last_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      req_r <= in_data;
    end
    if (state_r == S_MATCH) begin
      hv_r <= match;
    end
    status_r <= status_nxt;
    fval_r   <= fval_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cap_r    <= WGT_W'(4096);
      notify_r <= 1'b0;
      count_r  <= '0;
      total_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
      nq_r     <= '0;
      rd_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
      nq_r     <= nq_nxt;
      rd_r     <= rd_nxt;
      if (cfg_we) begin
        if (cfg_idx == CFG_CAPACITY) begin
          cap_r <= cfg_wdata[WGT_W-1:0];
        end else if (cfg_idx == CFG_NOTIFY) begin
          notify_r <= cfg_wdata[0];
        end
      end
    end
  end

  always_comb begin
    wlc_entry_t qe;
    qe = q_mem[rd_r[IW-1:0]];
    out_data.used_weight    = total_r[WGT_W-1:0];
    out_data.entry_count    = 5'(count_r);
    out_data.hit_count      = hits_r;
    out_data.miss_count     = misses_r;
    out_data.eviction_count = evicts_r;
    if (rd_r != nq_r) begin
      out_data.kind       = KIND_NOTICE;
      out_data.status     = ST_OK;
      out_data.key_out    = qe.key;
      out_data.value_out  = qe.value;
      out_data.weight_out = qe.weight;
      out_data.last       = 1'b0;
    end else begin
      out_data.kind       = KIND_FINAL;
      out_data.status     = status_r;
      out_data.key_out    = req_r.key;
      out_data.value_out  = fval_r;
      out_data.weight_out = '0;
      out_data.last       = 1'b1;
    end
  end

  assign out_valid = (state_r == S_EMIT);
  assign in_stall  = (state_r != S_IDLE);

endmodule

// ===== rtl/wlc_cell.sv =====
// one recency position of the cache: entry register, key compare, neighbor shift
// depends on wlc_pkg
module wlc_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wlc_pkg::wlc_cmd_t          cmd,
  input  wlc_pkg::wlc_entry_t        prev_i,
  input  wlc_pkg::wlc_entry_t        next_i,
  input  wlc_pkg::wlc_entry_t        load_i,
  input  logic [wlc_pkg::KEY_W-1:0]  key_i,
  output wlc_pkg::wlc_entry_t        ent_o,
  output logic                       match_o
);
  import wlc_pkg::*;

  wlc_entry_t ent_r;
  wlc_entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    case (cmd)
      CMD_HOLD: ent_nxt = ent_r;
      CMD_PREV: ent_nxt = prev_i;
      CMD_NEXT: ent_nxt = next_i;
      CMD_LOAD: ent_nxt = load_i;
      CMD_KILL: ent_nxt.valid = 1'b0;
      default:  ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o   = ent_r;
  assign match_o = ent_r.valid && (ent_r.key == key_i);

endmodule

// ===== rtl/wlc_checker.sv =====
// port-level checks of the weighted lru cache, bound to the top level
// depends on wlc_pkg and weighted_lru_cache_macros.svh
`include "weighted_lru_cache_macros.svh"

module wlc_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input wlc_pkg::wlc_in_t                  in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input wlc_pkg::wlc_out_t                 out_data,
  input logic                              cfg_we,
  input logic [wlc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input logic [wlc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import wlc_pkg::*;

  logic unused_ok;
  assign unused_ok = (ENTRIES != 0) && in_valid && cfg_we && (cfg_idx == CFG_CAPACITY)
                     && (|cfg_wdata) && (|in_data);

  `WLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `WLC_ASSERT_NOW(a_no_take_while_busy, out_valid, in_stall)
  `WLC_ASSERT_NOW(a_notice_not_last, out_valid && (out_data.kind == KIND_NOTICE), !out_data.last)
  `WLC_ASSERT_NOW(a_final_zero_wgt, out_valid && (out_data.kind == KIND_FINAL),
    out_data.last && (out_data.weight_out == '0))

endmodule

bind weighted_lru_cache wlc_checker #(.ENTRIES(ENTRIES)) u_wlc_checker (.*);
